[rtl/core/first_fit_block_allocator_assert.svh]
// Assertion macros shared by the allocator RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define FFBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FFBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/ffba_pkg.sv]
// Package for the first-fit block allocator: table entry type, probe result,
// request modes, status codes and register indices. No dependencies.
package ffba_pkg;

  localparam int TABLE_ENTRIES_DEF = 512;

  localparam logic [31:0] GRANULE     = 32'h0000_0100;
  localparam logic [31:0] GRANULE_M   = 32'h0000_00FF;
  localparam logic [31:0] MAX_SIZE    = 32'hFFFF_FF00;
  localparam logic [31:0] FIRST_ID    = 32'h0001_0000;
  localparam logic [31:0] RESET_LOW   = 32'h08C0_0000;
  localparam logic [31:0] RESET_HIGH  = 32'h0A00_0000;

  localparam logic [2:0] MODE_LOW     = 3'd0;
  localparam logic [2:0] MODE_HIGH    = 3'd1;
  localparam logic [2:0] MODE_ADDR    = 3'd2;
  localparam logic [2:0] MODE_LOW_AL  = 3'd3;
  localparam logic [2:0] MODE_HIGH_AL = 3'd4;
  localparam logic [2:0] MODE_FREE    = 3'd5;
  localparam logic [2:0] MODE_LOOKUP  = 3'd6;
  localparam logic [2:0] MODE_BAD     = 3'd7;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_ILLEGAL = 2'd1;
  localparam logic [1:0] STS_NOMEM   = 2'd2;
  localparam logic [1:0] STS_UNKNOWN = 2'd3;

  localparam logic CFG_HEAP_LOW  = 1'b0;
  localparam logic CFG_HEAP_HIGH = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_PREP, ST_START, ST_BOUND,
    ST_SCAN, ST_EVAL, ST_WRITE, ST_DONE
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] id;
    logic [31:0] base;
    logic [31:0] length;
  } entry_t;

  typedef struct packed {
    logic        clash;
    logic [32:0] next_end;
    logic [31:0] prev;
    logic        free_found;
    logic        id_found;
    logic [31:0] id_base;
  } probe_t;

endpackage

[rtl/core/ffba_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/ffba_probe.sv]
// Table scan unit: checks each entry read from the table against the current
// candidate and accumulates overlap, nearest ends, first free slot and id match.
// Depends on ffba_pkg.
module ffba_probe #(
  parameter int ENTRIES = ffba_pkg::TABLE_ENTRIES_DEF,
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            clr,
  input  logic            chk_v,
  input  logic [AW-1:0]   chk_idx,
  input  ffba_pkg::entry_t ent,
  input  logic [33:0]     cand,
  input  logic [31:0]     len,
  input  logic [31:0]     key_id,
  input  logic [31:0]     lo,
  input  logic [31:0]     hi,
  output ffba_pkg::probe_t res,
  output logic [AW-1:0]   free_idx,
  output logic [AW-1:0]   id_idx
);

  ffba_pkg::probe_t res_r, res_nxt;
  logic [AW-1:0]    free_idx_r, free_idx_nxt;
  logic [AW-1:0]    id_idx_r, id_idx_nxt;
  logic [32:0]      ent_end;
  logic [34:0]      cand_end;
  logic             hit;

  assign ent_end  = {1'b0, ent.base} + {1'b0, ent.length};
  assign cand_end = {1'b0, cand} + {3'b0, len};
  assign hit = ent.valid && ({1'b0, cand} < {2'b0, ent_end})
               && ({3'b0, ent.base} < cand_end);

  always_comb begin
    res_nxt      = res_r;
    free_idx_nxt = free_idx_r;
    id_idx_nxt   = id_idx_r;
    if (clr) begin
      res_nxt.clash      = 1'b0;
      res_nxt.next_end   = {1'b0, hi};
      res_nxt.prev       = lo;
      res_nxt.free_found = 1'b0;
      res_nxt.id_found   = 1'b0;
    end else if (chk_v) begin
      if (hit) begin
        res_nxt.clash = 1'b1;
        if (ent_end < res_r.next_end) begin
          res_nxt.next_end = ent_end;
        end
        if (ent.base > res_r.prev) begin
          res_nxt.prev = ent.base;
        end
      end
      if (!ent.valid && !res_r.free_found) begin
        res_nxt.free_found = 1'b1;
        free_idx_nxt       = chk_idx;
      end
      if (ent.valid && (ent.id == key_id) && !res_r.id_found) begin
        res_nxt.id_found = 1'b1;
        res_nxt.id_base  = ent.base;
        id_idx_nxt       = chk_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.clash      <= 1'b0;
      res_r.free_found <= 1'b0;
      res_r.id_found   <= 1'b0;
    end else begin
      res_r.clash      <= res_nxt.clash;
      res_r.free_found <= res_nxt.free_found;
      res_r.id_found   <= res_nxt.id_found;
    end
    res_r.next_end <= res_nxt.next_end;
    res_r.prev     <= res_nxt.prev;
    res_r.id_base  <= res_nxt.id_base;
    free_idx_r     <= free_idx_nxt;
    id_idx_r       <= id_idx_nxt;
  end

  assign res      = res_r;
  assign free_idx = free_idx_r;
  assign id_idx   = id_idx_r;

endmodule

[rtl/core/first_fit_block_allocator.sv]
// First-fit block allocator: a block table in one RAM, scanned entry by entry
// by ffba_probe under a request sequencer. Depends on ffba_pkg, ffba_ram, ffba_probe.
// A lookup, free or fixed-address request makes one full table scan; low and high requests
// make one full scan per placement probe. During a scan the table is read one entry per cycle;
// the next beat is taken in the same cycle the result is offered.
// Reset: synchronous; a clearing pass over every table entry follows, input held off.
`include "first_fit_block_allocator_assert.svh"

module first_fit_block_allocator #(
  parameter int TABLE_ENTRIES = ffba_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // request_size, want_value, block_id
  input  logic [2:0]  in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // status, new_id, base_address, zero pad
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [31:0] cfg_wdata
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int EW = $bits(ffba_pkg::entry_t);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

  ffba_pkg::state_t state_r, state_nxt;
  logic [2:0]  mode_r, mode_nxt;
  logic [31:0] size_r, size_nxt, want_r, want_nxt, key_r, key_nxt;
  logic [31:0] len_r, len_nxt, mask_r, mask_nxt;
  logic [33:0] cand_r, cand_nxt;
  logic [AW-1:0] slot_r, slot_nxt, idx_r, idx_nxt, chk_idx_r;
  logic        iss_r, iss_nxt, chk_v_r;
  ffba_pkg::entry_t wr_ent_r, wr_ent_nxt;
  logic [31:0] next_id_r, next_id_nxt, lo_r, hi_r;
  logic [1:0]  res_status_r, res_status_nxt;
  logic [31:0] res_id_r, res_id_nxt, res_base_r, res_base_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [31:0] out_id_r, out_id_nxt, out_base_r, out_base_nxt;

  ffba_pkg::entry_t rd_ent;
  logic [EW-1:0]    rd_bits;
  ffba_pkg::probe_t prb;
  logic [AW-1:0]    free_idx, id_idx;
  logic             ram_we, ram_re, probe_clr;
  logic [AW-1:0]    ram_waddr;

  logic is_low, is_high, is_addr, is_id, is_al;
  logic [31:0] al_raw, al;
  logic        al_bad;
  logic [32:0] len_sum;
  logic [31:0] len_c;
  logic [33:0] mask34, lo34, hi34, len34, cand_end;

  assign is_low  = (mode_r == ffba_pkg::MODE_LOW)  || (mode_r == ffba_pkg::MODE_LOW_AL);
  assign is_high = (mode_r == ffba_pkg::MODE_HIGH) || (mode_r == ffba_pkg::MODE_HIGH_AL);
  assign is_addr = (mode_r == ffba_pkg::MODE_ADDR);
  assign is_id   = (mode_r == ffba_pkg::MODE_FREE) || (mode_r == ffba_pkg::MODE_LOOKUP);
  assign is_al   = (mode_r == ffba_pkg::MODE_LOW_AL) || (mode_r == ffba_pkg::MODE_HIGH_AL);

  assign al_raw  = (want_r == 32'd0) ? ffba_pkg::GRANULE : want_r;
  assign al_bad  = |(al_raw & (al_raw - 32'd1));
  assign al      = (al_raw < ffba_pkg::GRANULE) ? ffba_pkg::GRANULE : al_raw;
  assign len_sum = {1'b0, size_r} + {1'b0, ffba_pkg::GRANULE_M};
  assign len_c   = (len_sum[31:8] == 24'd0) ? ffba_pkg::GRANULE : {len_sum[31:8], 8'h00};

  assign mask34   = {2'b00, mask_r};
  assign lo34     = {2'b00, lo_r};
  assign hi34     = {2'b00, hi_r};
  assign len34    = {2'b00, len_r};
  assign cand_end = cand_r + len34;

  assign ram_we    = (state_r == ffba_pkg::ST_CLEAR) || (state_r == ffba_pkg::ST_WRITE);
  assign ram_waddr = (state_r == ffba_pkg::ST_CLEAR) ? idx_r : slot_r;
  assign ram_re    = (state_r == ffba_pkg::ST_SCAN) && iss_r;
  assign probe_clr = (state_r != ffba_pkg::ST_SCAN);
  assign rd_ent    = ffba_pkg::entry_t'(rd_bits);

  ffba_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata((state_r == ffba_pkg::ST_CLEAR) ? EW'(0) : EW'(wr_ent_r)),
    .re   (ram_re),
    .raddr(idx_r),
    .rdata(rd_bits)
  );

  ffba_probe #(.ENTRIES(TABLE_ENTRIES)) u_probe (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (probe_clr),
    .chk_v   (chk_v_r),
    .chk_idx (chk_idx_r),
    .ent     (rd_ent),
    .cand    (cand_r),
    .len     (len_r),
    .key_id  (key_r),
    .lo      (lo_r),
    .hi      (hi_r),
    .res     (prb),
    .free_idx(free_idx),
    .id_idx  (id_idx)
  );

  assign in_tready  = (state_r == ffba_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_base_r, out_id_r, out_status_r};

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    size_nxt       = size_r;
    want_nxt       = want_r;
    key_nxt        = key_r;
    len_nxt        = len_r;
    mask_nxt       = mask_r;
    cand_nxt       = cand_r;
    slot_nxt       = slot_r;
    idx_nxt        = idx_r;
    iss_nxt        = iss_r;
    wr_ent_nxt     = wr_ent_r;
    next_id_nxt    = next_id_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_base_nxt   = res_base_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_base_nxt   = out_base_r;

    unique case (state_r)
      ffba_pkg::ST_CLEAR: begin
        idx_nxt = idx_r + AW'(1);
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = ffba_pkg::ST_IDLE;
        end
      end
      ffba_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          mode_nxt  = in_tuser;
          size_nxt  = in_tdata[31:0];
          want_nxt  = in_tdata[63:32];
          key_nxt   = in_tdata[95:64];
          state_nxt = ffba_pkg::ST_PREP;
        end
      end
      ffba_pkg::ST_PREP: begin
        res_id_nxt   = '0;
        res_base_nxt = '0;
        len_nxt      = len_c;
        mask_nxt     = is_al ? (al - 32'd1) : ffba_pkg::GRANULE_M;
        if (is_id) begin
          idx_nxt   = '0;
          iss_nxt   = 1'b1;
          state_nxt = ffba_pkg::ST_SCAN;
        end else if (mode_r == ffba_pkg::MODE_BAD || (is_al && al_bad)) begin
          res_status_nxt = ffba_pkg::STS_ILLEGAL;
          state_nxt      = ffba_pkg::ST_DONE;
        end else if (size_r > ffba_pkg::MAX_SIZE) begin
          res_status_nxt = ffba_pkg::STS_NOMEM;
          state_nxt      = ffba_pkg::ST_DONE;
        end else begin
          state_nxt = ffba_pkg::ST_START;
        end
      end
      ffba_pkg::ST_START: begin
        state_nxt = ffba_pkg::ST_BOUND;
        if (is_low) begin
          cand_nxt = (lo34 + mask34) & ~mask34;
        end else if (is_high) begin
          if (hi_r < lo_r || len_r > (hi_r - lo_r)) begin
            res_status_nxt = ffba_pkg::STS_NOMEM;
            state_nxt      = ffba_pkg::ST_DONE;
          end
          cand_nxt = (hi34 - len34) & ~mask34;
        end else begin
          cand_nxt = {2'b00, want_r};
        end
      end
      ffba_pkg::ST_BOUND: begin
        if ((is_low && cand_end <= hi34) || (is_high && cand_r >= lo34)
            || (is_addr && cand_r >= lo34 && cand_end <= hi34)) begin
          idx_nxt   = '0;
          iss_nxt   = 1'b1;
          state_nxt = ffba_pkg::ST_SCAN;
        end else begin
          res_status_nxt = ffba_pkg::STS_NOMEM;
          state_nxt      = ffba_pkg::ST_DONE;
        end
      end
      ffba_pkg::ST_SCAN: begin
        if (iss_r) begin
          if (idx_r == LAST_IDX) begin
            iss_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end
        if (chk_v_r && chk_idx_r == LAST_IDX) begin
          state_nxt = ffba_pkg::ST_EVAL;
        end
      end
      ffba_pkg::ST_EVAL: begin
        state_nxt = ffba_pkg::ST_DONE;
        if (is_id) begin
          if (!prb.id_found) begin
            res_status_nxt = ffba_pkg::STS_UNKNOWN;
          end else begin
            res_status_nxt = ffba_pkg::STS_OK;
            if (mode_r == ffba_pkg::MODE_FREE) begin
              wr_ent_nxt = '0;
              slot_nxt   = id_idx;
              state_nxt  = ffba_pkg::ST_WRITE;
            end else begin
              res_base_nxt = prb.id_base;
            end
          end
        end else if (!prb.clash) begin
          if (!prb.free_found) begin
            res_status_nxt = ffba_pkg::STS_NOMEM;
          end else begin
            res_status_nxt = ffba_pkg::STS_OK;
            res_id_nxt     = next_id_r;
            res_base_nxt   = cand_r[31:0];
            wr_ent_nxt     = '{valid: 1'b1, id: next_id_r, base: cand_r[31:0],
                               length: len_r};
            slot_nxt       = free_idx;
            next_id_nxt    = next_id_r + 32'd1;
            state_nxt      = ffba_pkg::ST_WRITE;
          end
        end else if (is_low) begin
          cand_nxt  = ({1'b0, prb.next_end} + mask34) & ~mask34;
          state_nxt = ffba_pkg::ST_BOUND;
        end else if (is_high && prb.prev > lo_r && prb.prev >= len_r) begin
          cand_nxt  = {2'b00, prb.prev - len_r} & ~mask34;
          state_nxt = ffba_pkg::ST_BOUND;
        end else begin
          res_status_nxt = ffba_pkg::STS_NOMEM;
        end
      end
      ffba_pkg::ST_WRITE: begin
        state_nxt = ffba_pkg::ST_DONE;
      end
      ffba_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          out_base_nxt   = res_base_r;
          state_nxt      = ffba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ffba_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffba_pkg::ST_CLEAR;
      idx_r       <= '0;
      iss_r       <= 1'b0;
      chk_v_r     <= 1'b0;
      next_id_r   <= ffba_pkg::FIRST_ID;
      out_valid_r <= 1'b0;
      lo_r        <= ffba_pkg::RESET_LOW;
      hi_r        <= ffba_pkg::RESET_HIGH;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      iss_r       <= iss_nxt;
      chk_v_r     <= ram_re;
      next_id_r   <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          ffba_pkg::CFG_HEAP_LOW:  lo_r <= cfg_wdata;
          ffba_pkg::CFG_HEAP_HIGH: hi_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
    chk_idx_r    <= idx_r;
    mode_r       <= mode_nxt;
    size_r       <= size_nxt;
    want_r       <= want_nxt;
    key_r        <= key_nxt;
    len_r        <= len_nxt;
    mask_r       <= mask_nxt;
    cand_r       <= cand_nxt;
    slot_r       <= slot_nxt;
    wr_ent_r     <= wr_ent_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_base_r   <= res_base_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_base_r   <= out_base_nxt;
  end

  `FFBA_ASSERT_NEXT(a_accept_prep, in_tvalid && in_tready, state_r == ffba_pkg::ST_PREP,
                    "accepted beat did not start decoding")
  `FFBA_ASSERT_NOW(a_we_state, ram_we && ram_re, 1'b0,
                   "table written while a scan read is issued")
  `FFBA_ASSERT_NOW(a_chk_scan, chk_v_r, state_r == ffba_pkg::ST_SCAN,
                   "table data checked outside a scan")
  `FFBA_ASSERT_NEXT(a_id_step, state_r == ffba_pkg::ST_WRITE && wr_ent_r.valid,
                    next_id_r == wr_ent_r.id + 32'd1,
                    "id counter out of step with the written entry")

endmodule

[bench/tb_first_fit_block_allocator.sv]
// Self-checking bench for first_fit_block_allocator: directed and random requests
// under several heap windows, checked against an in-bench allocator predictor.
// Depends on ffba_pkg and the allocator RTL.
`timescale 1ns / 100ps

module tb_first_fit_block_allocator;

  localparam int NENT = 512;
  localparam longint CYCLE_LIMIT = 1_000_000_000;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] new_id;
    logic [31:0] base;
  } reply_t;

  class alloc_scoreboard;
    bit          used [NENT];
    bit [31:0]   ids [NENT];
    bit [31:0]   bases [NENT];
    bit [31:0]   lens [NENT];
    bit [31:0]   next_id;
    bit [31:0]   heap_lo;
    bit [31:0]   heap_hi;
    reply_t      replies [$];
    int          errors;

    function void init();
      foreach (used[i]) used[i] = 0;
      next_id = ffba_pkg::FIRST_ID;
      heap_lo = ffba_pkg::RESET_LOW;
      heap_hi = ffba_pkg::RESET_HIGH;
      errors = 0;
    endfunction

    function bit overlaps(longint unsigned a, longint unsigned len, int i);
      longint unsigned b, e;
      b = bases[i];
      e = b + lens[i];
      return used[i] && a < e && b < a + len;
    endfunction

    function bit clash(longint unsigned a, longint unsigned len);
      for (int i = 0; i < NENT; i++) if (overlaps(a, len, i)) return 1;
      return 0;
    endfunction

    function bit fit_bottom(longint unsigned len, longint unsigned align,
                            output longint unsigned where);
      longint unsigned m, a, nx, e;
      m = align - 1;
      a = (longint'(heap_lo) + m) & ~m;
      where = 0;
      while (a + len <= heap_hi) begin
        if (!clash(a, len)) begin
          where = a;
          return 1;
        end
        nx = heap_hi;
        for (int i = 0; i < NENT; i++) begin
          if (overlaps(a, len, i)) begin
            e = longint'(bases[i]) + lens[i];
            if (e < nx) nx = e;
          end
        end
        a = (nx + m) & ~m;
      end
      return 0;
    endfunction

    function bit fit_top(longint unsigned len, longint unsigned align,
                         output longint unsigned where);
      longint unsigned m, lo, hi, a, pv;
      m = align - 1;
      lo = heap_lo;
      hi = heap_hi;
      where = 0;
      if (hi < lo || len > hi - lo) return 0;
      a = (hi - len) & ~m;
      while (a >= lo) begin
        if (!clash(a, len)) begin
          where = a;
          return 1;
        end
        pv = lo;
        for (int i = 0; i < NENT; i++)
          if (overlaps(a, len, i) && bases[i] > pv) pv = bases[i];
        if (pv <= lo || pv < len) return 0;
        a = (pv - len) & ~m;
      end
      return 0;
    endfunction

    function int slot_of(bit [31:0] id);
      for (int i = 0; i < NENT; i++) if (used[i] && ids[i] == id) return i;
      return -1;
    endfunction

    function void push(logic [1:0] st, logic [31:0] nid, logic [31:0] b);
      reply_t r;
      r.status = st;
      r.new_id = nid;
      r.base = b;
      replies.push_back(r);
    endfunction

    function void note_request(logic [2:0] mode, bit [31:0] size, bit [31:0] want,
                               bit [31:0] bid);
      longint unsigned align, len, where;
      bit [31:0] al;
      bit ok;
      int s;
      align = ffba_pkg::GRANULE;
      where = 0;
      ok = 0;
      if (mode == ffba_pkg::MODE_FREE || mode == ffba_pkg::MODE_LOOKUP) begin
        s = slot_of(bid);
        if (s < 0) push(ffba_pkg::STS_UNKNOWN, 0, 0);
        else if (mode == ffba_pkg::MODE_FREE) begin
          used[s] = 0;
          push(ffba_pkg::STS_OK, 0, 0);
        end else push(ffba_pkg::STS_OK, 0, bases[s]);
        return;
      end
      if (mode == ffba_pkg::MODE_BAD) begin
        push(ffba_pkg::STS_ILLEGAL, 0, 0);
        return;
      end
      if (mode == ffba_pkg::MODE_LOW_AL || mode == ffba_pkg::MODE_HIGH_AL) begin
        al = (want != 0) ? want : ffba_pkg::GRANULE;
        if ((al & (al - 1)) != 0) begin
          push(ffba_pkg::STS_ILLEGAL, 0, 0);
          return;
        end
        if (al < ffba_pkg::GRANULE) al = ffba_pkg::GRANULE;
        align = al;
      end
      if (size > ffba_pkg::MAX_SIZE) begin
        push(ffba_pkg::STS_NOMEM, 0, 0);
        return;
      end
      len = (longint'(size) + 255) & ~longint'(255);
      if (len == 0) len = ffba_pkg::GRANULE;
      if (mode == ffba_pkg::MODE_LOW || mode == ffba_pkg::MODE_LOW_AL)
        ok = fit_bottom(len, align, where);
      else if (mode == ffba_pkg::MODE_HIGH || mode == ffba_pkg::MODE_HIGH_AL)
        ok = fit_top(len, align, where);
      else if (want >= heap_lo && longint'(want) + len <= heap_hi && !clash(want, len)) begin
        where = want;
        ok = 1;
      end
      if (!ok) begin
        push(ffba_pkg::STS_NOMEM, 0, 0);
        return;
      end
      s = -1;
      for (int i = 0; i < NENT; i++) begin
        if (!used[i]) begin
          s = i;
          break;
        end
      end
      if (s < 0) begin
        push(ffba_pkg::STS_NOMEM, 0, 0);
        return;
      end
      used[s] = 1;
      ids[s] = next_id;
      bases[s] = where[31:0];
      lens[s] = len[31:0];
      next_id = next_id + 1;
      push(ffba_pkg::STS_OK, ids[s], bases[s]);
    endfunction

    function void check_reply(logic [71:0] d);
      reply_t r;
      if (replies.size() == 0) begin
        $error("unexpected result beat %h", d);
        errors++;
        return;
      end
      r = replies.pop_front();
      if (d[1:0] !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, d[1:0]);
        errors++;
      end
      if (d[33:2] !== r.new_id) begin
        $error("new_id: expected %h, got %h", r.new_id, d[33:2]);
        errors++;
      end
      if (d[65:34] !== r.base) begin
        $error("base_address: expected %h, got %h", r.base, d[65:34]);
        errors++;
      end
    endfunction

    function int live_count();
      int n;
      n = 0;
      foreach (used[i]) n += used[i];
      return n;
    endfunction

    function bit [31:0] some_live(bit want_base);
      int q [$];
      int k;
      foreach (used[i]) if (used[i]) q.push_back(i);
      if (q.size() == 0) return $urandom;
      k = q[$urandom_range(0, q.size() - 1)];
      return want_base ? bases[k] : ids[k];
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;   // request_size, want_value, block_id
  logic [2:0]  in_tuser;   // mode
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // status, new_id, base_address, zero pad
  logic        cfg_we;
  logic        cfg_addr;
  logic [31:0] cfg_wdata;

  alloc_scoreboard sb;
  bit calm;
  bit long_hold;

  first_fit_block_allocator u_top (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    longint n;
    n = 0;
    forever begin
      @(posedge clk);
      n++;
      if (n > CYCLE_LIMIT) begin
        $display("first_fit_block_allocator: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int hold;
    int r;
    hold = 0;
    out_tready <= 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check_reply(out_tdata);
      if (long_hold) begin
        long_hold = 0;
        hold = 4000;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 0;
      end else begin
        r = $urandom_range(0, 99);
        if (calm || r < 75) out_tready <= 1;
        else begin
          out_tready <= 0;
          hold = (r < 97) ? $urandom_range(0, 3) : $urandom_range(20, 200);
        end
      end
    end
  end

  task automatic send(logic [2:0] mode, bit [31:0] size, bit [31:0] want, bit [31:0] bid);
    int gap;
    int r;
    in_tvalid <= 1;
    in_tuser <= mode;
    in_tdata <= {bid, want, size};
    do @(posedge clk); while (!in_tready);
    sb.note_request(mode, size, want, bid);
    r = $urandom_range(0, 99);
    gap = (calm || r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(20, 150);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.replies.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_window(bit [31:0] lo, bit [31:0] hi);
    drain();
    cfg_we <= 1;
    cfg_addr <= ffba_pkg::CFG_HEAP_LOW;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_addr <= ffba_pkg::CFG_HEAP_HIGH;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we <= 0;
    sb.heap_lo = lo;
    sb.heap_hi = hi;
  endtask

  task automatic random_request();
    int r;
    logic [2:0] mode;
    bit [31:0] size, want, bid;
    r = $urandom_range(0, 99);
    if (sb.live_count() > 10 && r < 30) mode = ffba_pkg::MODE_FREE;
    else mode = 3'($urandom_range(0, 7));
    r = $urandom_range(0, 99);
    if (r < 60) size = $urandom_range(0, 32'h2000);
    else if (r < 75) size = $urandom_range(0, sb.heap_hi - sb.heap_lo);
    else if (r < 90) size = $urandom;
    else size = ffba_pkg::MAX_SIZE + $urandom_range(0, 255) - 2;
    r = $urandom_range(0, 99);
    if (mode == ffba_pkg::MODE_LOW_AL || mode == ffba_pkg::MODE_HIGH_AL) begin
      if (r < 70) want = 32'd1 << $urandom_range(0, 31);
      else if (r < 80) want = 0;
      else want = $urandom;
    end else if (r < 50) want = sb.heap_lo + ($urandom_range(0, 64) << 8);
    else if (r < 75) want = sb.some_live(1) + ($urandom_range(0, 3) << 8);
    else want = $urandom;
    bid = ($urandom_range(0, 99) < 80) ? sb.some_live(0) : $urandom;
    send(mode, size, want, bid);
  endtask

  initial begin
    bit [31:0] lows [5];
    bit [31:0] highs [5];
    sb = new();
    sb.init();
    calm = 0;
    long_hold = 0;
    rst_n <= 0;
    in_tvalid <= 0;
    in_tdata <= 0;
    in_tuser <= 0;
    cfg_we <= 0;
    cfg_addr <= 0;
    cfg_wdata <= 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    do @(posedge clk); while (!in_tready);

    send(ffba_pkg::MODE_LOW, 0, 0, 0);
    send(ffba_pkg::MODE_HIGH, 1, 0, 0);
    send(ffba_pkg::MODE_ADDR, 32'h1FF, ffba_pkg::RESET_LOW + 32'h1000, 0);
    send(ffba_pkg::MODE_ADDR, 32'h100, ffba_pkg::RESET_LOW + 32'h1100, 0);
    send(ffba_pkg::MODE_LOW_AL, 32'h300, 0, 0);
    send(ffba_pkg::MODE_LOW_AL, 32'h300, 3, 0);
    send(ffba_pkg::MODE_LOW_AL, 32'h10, 1, 0);
    send(ffba_pkg::MODE_HIGH_AL, 32'h1234, 32'h10000, 0);
    send(ffba_pkg::MODE_HIGH_AL, 32'h100, 32'h8000_0000, 0);
    send(ffba_pkg::MODE_LOW, 32'hFFFF_FF01, 0, 0);
    send(ffba_pkg::MODE_HIGH, 32'hFFFF_FFFF, 0, 0);
    send(ffba_pkg::MODE_LOW, ffba_pkg::MAX_SIZE, 0, 0);
    send(ffba_pkg::MODE_LOOKUP, 0, 0, ffba_pkg::FIRST_ID);
    send(ffba_pkg::MODE_LOOKUP, 0, 0, 32'hFFFF_FFFF);
    send(ffba_pkg::MODE_FREE, 0, 0, ffba_pkg::FIRST_ID + 1);
    send(ffba_pkg::MODE_FREE, 0, 0, ffba_pkg::FIRST_ID + 1);
    send(ffba_pkg::MODE_BAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(ffba_pkg::MODE_ADDR, 0, ffba_pkg::RESET_LOW - 32'h100, 0);
    send(ffba_pkg::MODE_ADDR, 32'h200, ffba_pkg::RESET_HIGH - 32'h100, 0);

    set_window(32'h0, 32'h1_0000);
    send(ffba_pkg::MODE_LOW, 32'h80, 0, 0);
    send(ffba_pkg::MODE_ADDR, 0, 0, 0);
    set_window(32'h2000, 32'h1000);
    send(ffba_pkg::MODE_LOW, 0, 0, 0);
    send(ffba_pkg::MODE_HIGH_AL, 0, 0, 0);
    send(ffba_pkg::MODE_LOOKUP, 0, 0, ffba_pkg::FIRST_ID);
    set_window(32'h0, 32'hFFFF_FFFF);
    send(ffba_pkg::MODE_HIGH, ffba_pkg::MAX_SIZE - 32'h1000, 0, 0);
    send(ffba_pkg::MODE_FREE, 0, 0, sb.next_id - 1);

    lows = '{ffba_pkg::RESET_LOW, 32'h0, 32'h0, 32'hFFFF_0000, 32'h0000_0FFF};
    highs = '{ffba_pkg::RESET_HIGH, 32'h2_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0004_0000};
    for (int p = 0; p < 5; p++) begin
      set_window(lows[p], highs[p]);
      for (int k = 0; k < 111; k++) begin
        calm = (k >= 40 && k < 60);
        if (p == 1 && k == 70) long_hold = 1;
        random_request();
      end
      calm = 0;
    end

    drain();
    if (sb.errors == 0) $display("first_fit_block_allocator: match");
    else $display("first_fit_block_allocator: mismatch");
    $finish;
  end
endmodule
